>>> design/rcpd_pkg.sv
`timescale 1ns / 1ps

package rcpd_pkg;

  localparam int PartW   = 18;
  localparam int FixHalfW = 20;
  localparam int DatHalfW = 16;
  localparam int DigitW  = 15;
  localparam int RevW    = 30;
  localparam int RollW   = 28;
  localparam int FixW    = 40;
  localparam int DatW    = 32;

  localparam logic [15:0] NibbleValidMask = 16'h0777;
  localparam logic [RevW-1:0] RollingLimit = 30'h1000_0000;
  localparam logic [DigitW-1:0] Pow3Nine = 15'd19683;

  // Decoded view of one half.
  typedef struct packed {
    logic                ok;
    logic [PartW-1:0]    roll;
    logic [FixHalfW-1:0] fix;
    logic [DatHalfW-1:0] dat;
  } half_t;

  // Part order: three 2-bit destination slots, first part in the top bits.
  function automatic logic [5:0] order_of(input logic [3:0] nib);
    logic [5:0] o;
    unique case (nib)
      4'd0:    o = 6'd9;
      4'd1:    o = 6'd33;
      4'd2:    o = 6'd6;
      4'd4:    o = 6'd24;
      4'd5:    o = 6'd18;
      4'd6:    o = 6'd36;
      4'd8:    o = 6'd24;
      4'd9:    o = 6'd36;
      4'd10:   o = 6'd6;
      default: o = 6'd0;
    endcase
    return o;
  endfunction

  // Part inversion: bit 2 inverts the first part, bit 0 the last.
  function automatic logic [2:0] invert_of(input logic [3:0] nib);
    logic [2:0] v;
    unique case (nib)
      4'd0:    v = 3'd6;
      4'd1:    v = 3'd2;
      4'd2:    v = 3'd1;
      4'd4:    v = 3'd7;
      4'd5:    v = 3'd5;
      4'd6:    v = 3'd3;
      4'd8:    v = 3'd4;
      4'd9:    v = 3'd0;
      4'd10:   v = 3'd5;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/rolling_code_v2_packet_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  tdata (low bit up)                                 tuser
// in_      slave      first_half[63:0], second_half[127:64]              pkt_kind
// out_     master     rolling[27:0], fixed_code[67:28], payload[99:68]   error
//
// One packet enters per cycle while in_tready is high; its result passes through the
// stage registers listed below, so up to four items are held in flight.
// Stages: half unscramble and checks, ternary partial sums and parity,
// combine multiply-add, then range check, bit reversal and output masking.
// Each stage holds its item until the next stage has room, so a stall on the
// output side fills bubbles first and then holds in_tready low; nothing is lost.
// Reset clears only the stage valid bits.
module rolling_code_v2_packet_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // first_half, second_half
  input  logic         in_tuser,   // pkt_kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // rolling, fixed_code, payload, zero fill
  output logic         out_tuser   // error
);

  localparam int DW   = rcpd_pkg::DigitW;
  localparam int RevW = rcpd_pkg::RevW;

  function automatic logic [DW-1:0] horner9(input logic [17:0] digits);
    logic [DW-1:0] acc;
    acc = '0;
    for (int k = 8; k >= 0; k--) begin
      acc = (acc << 1) + acc + {{(DW-2){1'b0}}, digits[2*k +: 2]};
    end
    return acc;
  endfunction

  // Stage handshake
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  // Stage 1
  rcpd_pkg::half_t h1_nxt, h2_nxt;
  rcpd_pkg::half_t h1_r, h2_r;
  logic            ft1_r;

  // Stage 2
  logic [17:0]                 dig_hi, dig_lo;
  logic [3:0]                  par;
  logic [rcpd_pkg::DatW-1:0]   dat_nxt;
  logic                        ok2_nxt;
  logic                        ok2_r;
  logic [DW-1:0]               hi_r, lo_r;
  logic [rcpd_pkg::FixW-1:0]   fix2_r, fix3_r;
  logic [rcpd_pkg::DatW-1:0]   dat2_r, dat3_r;

  // Stage 3
  logic [rcpd_pkg::RevW-1:0]   rev_nxt;
  logic [rcpd_pkg::RevW-1:0]   rev_r;
  logic                        ok3_r;

  // Stage 4
  logic                        ok4;
  logic [rcpd_pkg::RollW-1:0]  roll_rev;
  logic [rcpd_pkg::RollW-1:0]  roll_r;
  logic [rcpd_pkg::FixW-1:0]   fix4_r;
  logic [rcpd_pkg::DatW-1:0]   dat4_r;
  logic                        err_r;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: both halves in parallel.
  rcpd_half u_half_a (
    .ftype     (in_tuser),
    .half_word (in_tdata[63:0]),
    .res       (h1_nxt)
  );

  rcpd_half u_half_b (
    .ftype     (in_tuser),
    .half_word (in_tdata[127:64]),
    .res       (h2_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      h1_r  <= h1_nxt;
      h2_r  <= h2_nxt;
      ft1_r <= in_tuser;
    end
  end

  // Stage 2: the 18 ternary digits split into two Horner runs of nine.
  assign dig_hi = {h2_r.roll[9:8], h1_r.roll[9:8], h2_r.roll[17:10], h1_r.roll[17:12]};
  assign dig_lo = {h1_r.roll[11:10], h2_r.roll[7:0], h1_r.roll[7:0]};

  assign dat_nxt = ft1_r ? {h1_r.dat, h2_r.dat} : '0;

  // Fixed-code bits 35:32 come from bits 15:12 of the first half's fixed field.
  always_comb begin
    par = h1_r.fix[15:12];
    for (int n = 0; n < 8; n++) begin
      par = par ^ dat_nxt[4*n +: 4];
    end
  end

  assign ok2_nxt = h1_r.ok && h2_r.ok && (!ft1_r || par == 4'h0);

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      hi_r   <= horner9(dig_hi);
      lo_r   <= horner9(dig_lo);
      ok2_r  <= ok2_nxt;
      fix2_r <= {h1_r.fix, h2_r.fix};
      dat2_r <= dat_nxt;
    end
  end

  // Stage 3: combine the two partial sums.
  assign rev_nxt = RevW'(hi_r) * RevW'(rcpd_pkg::Pow3Nine) + RevW'(lo_r);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      rev_r  <= rev_nxt;
      ok3_r  <= ok2_r;
      fix3_r <= fix2_r;
      dat3_r <= dat2_r;
    end
  end

  // Stage 4: range check, bit reversal and zeroing on error.
  assign ok4 = ok3_r && (rev_r < rcpd_pkg::RollingLimit);

  always_comb begin
    for (int b = 0; b < rcpd_pkg::RollW; b++) begin
      roll_rev[b] = rev_r[rcpd_pkg::RollW-1-b];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      roll_r <= ok4 ? roll_rev : '0;
      fix4_r <= ok4 ? fix3_r : '0;
      dat4_r <= ok4 ? dat3_r : '0;
      err_r  <= !ok4;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {4'h0, dat4_r, fix4_r, roll_r};
  assign out_tuser  = err_r;

endmodule

>>> design/rcpd_half.sv
`timescale 1ns / 1ps

module rcpd_half (
  input  logic                 ftype,
  input  logic [63:0]          half_word,
  output rcpd_pkg::half_t      res
);

  logic [7:0]               ind;
  logic [5:0]               ord;
  logic [2:0]               inv;
  logic [rcpd_pkg::PartW-1:0] pp [3];
  logic [rcpd_pkg::PartW-1:0] parts [4];
  logic                     type_ok;
  logic                     nib_ok;
  logic                     echo_ok;
  logic                     digit_ok;

  assign ind     = half_word[61:54];
  assign ord     = rcpd_pkg::order_of(ind[7:4]);
  assign inv     = rcpd_pkg::invert_of(ind[3:0]);
  assign type_ok = (half_word[63:62] == {1'b0, ftype});
  assign nib_ok  = rcpd_pkg::NibbleValidMask[ind[7:4]] & rcpd_pkg::NibbleValidMask[ind[3:0]];

  // Triplets are interleaved from bit 53 downward; short frames stop at part bit 8.
  always_comb begin
    for (int i = 0; i < rcpd_pkg::PartW; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp[j][i] = (ftype || i >= 8) ? half_word[2 + 3*i - j] : 1'b0;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      parts[p] = '0;
    end
    parts[ord[5:4]] = inv[2] ? ~pp[0] : pp[0];
    parts[ord[3:2]] = inv[1] ? ~pp[1] : pp[1];
    parts[ord[1:0]] = inv[0] ? ~pp[2] : pp[2];
  end

  assign echo_ok = !ftype || (parts[2][7:0] == ind);

  always_comb begin
    digit_ok = 1'b1;
    for (int d = 8; d < rcpd_pkg::PartW; d += 2) begin
      if (parts[2][d +: 2] == 2'b11) begin
        digit_ok = 1'b0;
      end
    end
  end

  assign res.ok   = type_ok & nib_ok & echo_ok & digit_ok;
  assign res.roll = {parts[2][17:8], ind};
  assign res.fix  = {parts[0][17:8], parts[1][17:8]};
  assign res.dat  = {parts[0][7:0], parts[1][7:0]};

endmodule

>>> design/rcpd_checker.sv
`timescale 1ns / 1ps

module rcpd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error item carries nonzero fields");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[99:68] != 32'h0 |->
      (out_tdata[63:60] ^ out_tdata[71:68] ^ out_tdata[75:72] ^ out_tdata[79:76] ^
       out_tdata[83:80] ^ out_tdata[87:84] ^ out_tdata[91:88] ^ out_tdata[95:92] ^
       out_tdata[99:96]) == 4'h0)
    else $error("payload parity broken on a good item");

endmodule

bind rolling_code_v2_packet_decoder rcpd_checker u_rcpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/rcpd_decode_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the packet decoder, predicts the result of every
// accepted packet and compares each delivered result against the oldest
// prediction still waiting.
module rcpd_decode_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending,
  output int           checked_count,
  output int           rejected_count
);

  typedef struct packed {
    logic [27:0] rolling;
    logic [39:0] fixed_code;
    logic [31:0] payload;
    logic        error;
  } decoded_t;

  decoded_t pending_decodes[$];
  decoded_t want;

  // Destination slots of the three scrambled parts, first part in the top bits.
  function automatic logic [5:0] part_order(input logic [3:0] nib);
    case (nib)
      4'd0:    return 6'd9;
      4'd1:    return 6'd33;
      4'd2:    return 6'd6;
      4'd4:    return 6'd24;
      4'd5:    return 6'd18;
      4'd6:    return 6'd36;
      4'd8:    return 6'd24;
      4'd9:    return 6'd36;
      4'd10:   return 6'd6;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [2:0] part_flip(input logic [3:0] nib);
    case (nib)
      4'd0:    return 3'd6;
      4'd1:    return 3'd2;
      4'd2:    return 3'd1;
      4'd4:    return 3'd7;
      4'd5:    return 3'd5;
      4'd6:    return 3'd3;
      4'd8:    return 3'd4;
      4'd9:    return 3'd0;
      4'd10:   return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic unscramble_half(input logic ftype, input logic [63:0] h,
                                           output logic [17:0] roll,
                                           output logic [19:0] fix,
                                           output logic [15:0] dat);
    logic [7:0]        ind;
    logic [5:0]        ord;
    logic [2:0]        inv;
    logic [2:0][17:0]  pp;
    logic [3:0][17:0]  part;
    logic              good;
    int                k;
    int                stop;
    ind  = h[61:54];
    good = 1'b1;
    if (h[63:62] != {1'b0, ftype}) good = 1'b0;
    if (!rcpd_pkg::NibbleValidMask[ind[7:4]] || !rcpd_pkg::NibbleValidMask[ind[3:0]])
      good = 1'b0;
    ord  = part_order(ind[7:4]);
    inv  = part_flip(ind[3:0]);
    pp   = '0;
    k    = 10;
    stop = ftype ? 0 : 8;
    // Bits arrive as interleaved triplets, most significant part bit first.
    for (int i = 17; i >= stop; i--) begin
      for (int j = 0; j < 3; j++) begin
        pp[j][i] = h[63-k];
        k++;
      end
    end
    part = '0;
    part[ord[5:4]] = pp[0] ^ {18{inv[2]}};
    part[ord[3:2]] = pp[1] ^ {18{inv[1]}};
    part[ord[1:0]] = pp[2] ^ {18{inv[0]}};
    if (ftype && part[2][7:0] != ind) good = 1'b0;
    for (int i = 8; i < 18; i += 2)
      if (part[2][i +: 2] == 2'b11) good = 1'b0;
    roll = {part[2][17:8], ind};
    fix  = {part[0][17:8], part[1][17:8]};
    dat  = {part[0][7:0], part[1][7:0]};
    return good;
  endfunction

  function automatic decoded_t decode_packet(input logic ftype, input logic [63:0] first_h,
                                             input logic [63:0] second_h);
    decoded_t   d;
    logic [17:0] r1, r2;
    logic [19:0] f1, f2;
    logic [15:0] d1, d2;
    logic [31:0] acc;
    logic [3:0]  par;
    logic        ok;
    ok = unscramble_half(ftype, first_h, r1, f1, d1);
    ok = unscramble_half(ftype, second_h, r2, f2, d2) && ok;
    // Eighteen base-3 digits, gathered alternately from the two halves.
    acc = 32'(r2[9:8]);
    acc = acc * 3 + 32'(r1[9:8]);
    for (int s = 16; s >= 10; s -= 2) acc = acc * 3 + 32'(r2[s +: 2]);
    for (int s = 16; s >= 10; s -= 2) acc = acc * 3 + 32'(r1[s +: 2]);
    for (int s = 6; s >= 0; s -= 2) acc = acc * 3 + 32'(r2[s +: 2]);
    for (int s = 6; s >= 0; s -= 2) acc = acc * 3 + 32'(r1[s +: 2]);
    if (acc >= 32'(rcpd_pkg::RollingLimit)) ok = 1'b0;
    for (int b = 0; b < 28; b++) d.rolling[27-b] = acc[b];
    d.fixed_code = {f1, f2};
    d.payload    = '0;
    if (ftype) begin
      d.payload = {d1, d2};
      par = d.fixed_code[35:32];
      for (int b = 0; b < 32; b += 4) par ^= d.payload[b +: 4];
      if (par != 4'd0) ok = 1'b0;
    end
    if (!ok) begin
      d.rolling    = '0;
      d.fixed_code = '0;
      d.payload    = '0;
    end
    d.error = !ok;
    return d;
  endfunction

  task automatic field_check(input string name, input logic [39:0] exp_v,
                             input logic [39:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count     = 0;
      pending        = 0;
      checked_count  = 0;
      rejected_count = 0;
      pending_decodes.delete();
    end else begin
      if (in_tvalid && in_tready)
        pending_decodes.push_back(decode_packet(in_tuser, in_tdata[63:0], in_tdata[127:64]));
      if (out_tvalid && out_tready) begin
        if (pending_decodes.size() == 0) begin
          $error("result item with no packet outstanding: tdata %h, error %b",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = pending_decodes.pop_front();
          checked_count++;
          if (want.error) rejected_count++;
          field_check("rolling", 40'(want.rolling), 40'(out_tdata[27:0]));
          field_check("fixed_code", want.fixed_code, out_tdata[67:28]);
          field_check("payload", 40'(want.payload), 40'(out_tdata[99:68]));
          field_check("error", 40'(want.error), 40'(out_tuser));
        end
      end
      pending = pending_decodes.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int RandomPackets = 1300;
  localparam int QuietTail     = 200;
  localparam int LongHold      = 60;

  typedef struct packed {
    logic                   ftype;
    logic [1:0][1:0]        hdr;
    logic [1:0][7:0]        ind;
    logic [1:0][2:0][17:0]  part;
  } packet_fields_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [127:0] in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tready = 1'b0;
  logic         in_tready;
  logic         out_tvalid;
  logic [103:0] out_tdata;
  logic         out_tuser;

  int fail_count, pending, checked_count, rejected_count;
  bit bursts_on = 1'b1;
  bit long_hold = 1'b0;
  int hold_count = 0;

  always #5 clk = ~clk;

  rolling_code_v2_packet_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rcpd_decode_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked_count  (checked_count),
    .rejected_count (rejected_count)
  );

  function automatic logic [3:0] valid_nib(input int idx);
    case (idx)
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd2;
      3:       return 4'd4;
      4:       return 4'd5;
      5:       return 4'd6;
      6:       return 4'd8;
      7:       return 4'd9;
      default: return 4'd10;
    endcase
  endfunction

  function automatic logic [3:0] bad_nib();
    case ($urandom_range(0, 6))
      0:       return 4'd3;
      1:       return 4'd7;
      2:       return 4'd11;
      3:       return 4'd12;
      4:       return 4'd13;
      5:       return 4'd14;
      default: return 4'd15;
    endcase
  endfunction

  function automatic logic [7:0] random_ind();
    return {valid_nib($urandom_range(0, 8)), valid_nib($urandom_range(0, 8))};
  endfunction

  function automatic logic [5:0] slot_order(input logic [3:0] nib);
    case (nib)
      4'd0:    return 6'd9;
      4'd1:    return 6'd33;
      4'd2:    return 6'd6;
      4'd4:    return 6'd24;
      4'd5:    return 6'd18;
      4'd6:    return 6'd36;
      4'd8:    return 6'd24;
      4'd9:    return 6'd36;
      4'd10:   return 6'd6;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [2:0] flip_mask(input logic [3:0] nib);
    case (nib)
      4'd0:    return 3'd6;
      4'd1:    return 3'd2;
      4'd2:    return 3'd1;
      4'd4:    return 3'd7;
      4'd5:    return 3'd5;
      4'd6:    return 3'd3;
      4'd8:    return 3'd4;
      4'd9:    return 3'd0;
      4'd10:   return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  // Well-formed packet content: digits kept below 3, indicator echoed on
  // frame 1 and the last payload nibble chosen so that nibble parity holds.
  function automatic packet_fields_t make_fields(input logic ftype, input logic [7:0] ind0,
                                                 input logic [7:0] ind1);
    packet_fields_t f;
    f.ftype  = ftype;
    f.ind[0] = ind0;
    f.ind[1] = ind1;
    for (int hf = 0; hf < 2; hf++) begin
      f.hdr[hf]     = {1'b0, ftype};
      f.part[hf][0] = 18'($urandom);
      f.part[hf][1] = 18'($urandom);
      f.part[hf][2] = 18'($urandom);
      for (int d = 8; d < 18; d += 2) f.part[hf][2][d +: 2] = 2'($urandom_range(0, 2));
      if (ftype) f.part[hf][2][7:0] = f.ind[hf];
    end
    if (ftype)
      f.part[1][1][3:0] = f.part[0][0][13:10] ^ f.part[0][0][7:4] ^ f.part[0][0][3:0]
                        ^ f.part[0][1][7:4] ^ f.part[0][1][3:0] ^ f.part[1][0][7:4]
                        ^ f.part[1][0][3:0] ^ f.part[1][1][7:4];
    return f;
  endfunction

  function automatic logic [63:0] pack_half(input logic ftype, input logic [1:0] hdr,
                                            input logic [7:0] ind,
                                            input logic [2:0][17:0] part);
    logic [63:0]      h;
    logic [5:0]       ord;
    logic [2:0]       inv;
    logic [2:0][17:0] pp;
    int               k;
    int               stop;
    ord   = slot_order(ind[7:4]);
    inv   = flip_mask(ind[3:0]);
    pp[0] = part[ord[5:4]] ^ {18{inv[2]}};
    pp[1] = part[ord[3:2]] ^ {18{inv[1]}};
    pp[2] = part[ord[1:0]] ^ {18{inv[0]}};
    // Bits a short frame does not use keep random filler.
    h = {$urandom, $urandom};
    h[63:62] = hdr;
    h[61:54] = ind;
    k    = 10;
    stop = ftype ? 0 : 8;
    for (int i = 17; i >= stop; i--) begin
      for (int j = 0; j < 3; j++) begin
        h[63-k] = pp[j][i];
        k++;
      end
    end
    return h;
  endfunction

  task automatic send_raw(input logic ftype, input logic [63:0] first_h,
                          input logic [63:0] second_h);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {second_h, first_h};
    in_tuser  <= ftype;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_fields(input packet_fields_t f);
    send_raw(f.ftype, pack_half(f.ftype, f.hdr[0], f.ind[0], f.part[0]),
             pack_half(f.ftype, f.hdr[1], f.ind[1], f.part[1]));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        long_hold = 1'b0;
        hold_count++;
      end else if (bursts_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("rolling_code_v2_packet_decoder: mismatch");
    $finish;
  end

  initial begin
    packet_fields_t f;
    logic [63:0]    h1, h2;
    int             pick;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, every valid indicator nibble, each failure kind.
    send_raw(1'b0, '0, '0);
    send_raw(1'b1, '1, '1);
    send_raw(1'b0, '1, '1);
    send_raw(1'b1, '0, '0);
    for (int n = 0; n < 9; n++)
      send_fields(make_fields(1'(n % 2), {valid_nib(n), valid_nib(8 - n)},
                              {valid_nib(8 - n), valid_nib(n)}));
    f = make_fields(1'b1, random_ind(), random_ind());
    f.ind[0][7:4] = 4'd7;
    send_fields(f);
    f = make_fields(1'b0, random_ind(), random_ind());
    f.ind[1][3:0] = 4'd15;
    send_fields(f);
    // Digit of 3 in the rolling part.
    f = make_fields(1'b0, random_ind(), random_ind());
    f.part[1][2][13:12] = 2'b11;
    send_fields(f);
    // Indicator echo broken on a long frame.
    f = make_fields(1'b1, random_ind(), random_ind());
    f.part[0][2][7:0] ^= 8'h01;
    send_fields(f);
    // All digits at 2: the combined value overflows the rolling range.
    f = make_fields(1'b0, 8'hAA, 8'hAA);
    f.part[0][2][17:8] = 10'b1010101010;
    f.part[1][2][17:8] = 10'b1010101010;
    send_fields(f);
    // Parity broken by one payload bit.
    f = make_fields(1'b1, random_ind(), random_ind());
    f.part[1][1][0] ^= 1'b1;
    send_fields(f);
    f = make_fields(1'b0, random_ind(), random_ind());
    f.hdr[0] = 2'd2;
    send_fields(f);
    f = make_fields(1'b1, random_ind(), random_ind());
    f.hdr[1] = 2'd3;
    send_fields(f);
    f = make_fields(1'b1, random_ind(), random_ind());
    f.hdr[1] = 2'd0;
    send_fields(f);
    send_fields(make_fields(1'b0, random_ind(), random_ind()));
    send_fields(make_fields(1'b1, random_ind(), random_ind()));

    for (int i = 0; i < RandomPackets; i++) begin
      if (i == RandomPackets - QuietTail) bursts_on = 1'b0;
      if (i == 300 || i == 800) long_hold = 1'b1;
      if (i == 500 || i == 1000) drain();
      f    = make_fields(1'($urandom_range(0, 1)), random_ind(), random_ind());
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_fields(f);
      end else if (pick < 80) begin
        h1 = pack_half(f.ftype, f.hdr[0], f.ind[0], f.part[0]);
        h2 = pack_half(f.ftype, f.hdr[1], f.ind[1], f.part[1]);
        if ($urandom_range(0, 1)) h1[$urandom_range(0, 63)] ^= 1'b1;
        else h2[$urandom_range(0, 63)] ^= 1'b1;
        send_raw(f.ftype, h1, h2);
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: f.hdr[$urandom_range(0, 1)] = 2'($urandom_range(0, 3));
          1: f.ind[$urandom_range(0, 1)][$urandom_range(0, 1) * 4 +: 4] = bad_nib();
          2: f.part[$urandom_range(0, 1)][2][$urandom_range(4, 8) * 2 +: 2] = 2'b11;
          default: f.part[$urandom_range(0, 1)][2][$urandom_range(0, 7)] ^= 1'b1;
        endcase
        send_fields(f);
      end else begin
        send_raw(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Checked %0d decoded packets, %0d of them rejected by a frame, indicator,",
             checked_count, rejected_count);
    $display("digit, range or parity check; output held off %0d times, input drained twice.",
             hold_count);
    if (fail_count == 0) begin
      $display("rolling_code_v2_packet_decoder: match");
    end else begin
      $display("rolling_code_v2_packet_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rcpd_pkg.sv
design/rcpd_half.sv
design/rolling_code_v2_packet_decoder.sv
design/rcpd_checker.sv
tb/rcpd_decode_checker.sv
tb/tb.sv
